>>> hw/rtl/timed_winch_sequencer_assert.svh
// ----------------------------------------------------------------------------
// timed_winch_sequencer_assert.svh
// assertion macros shared by the winch sequencer rtl
// ----------------------------------------------------------------------------
`ifndef TIMED_WINCH_SEQUENCER_ASSERT_SVH
`define TIMED_WINCH_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TWSEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timed_winch_sequencer: same-cycle check failed");

// next-cycle implication
`define TWSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timed_winch_sequencer: next-cycle check failed");

`else

`define TWSEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TWSEQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/twseq_pkg.sv
// ----------------------------------------------------------------------------
// twseq_pkg
// types and constants of the timed winch sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package twseq_pkg;

  localparam int CFG_W          = 16;
  localparam int TICK_WIDTH_DEF = 16;

  localparam logic [CFG_W-1:0] LOWER_TICKS_RST   = 16'd120;
  localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = 16'd20;
  localparam logic [CFG_W-1:0] RETRACT_TICKS_RST = 16'd140;

  // configuration register indexes
  localparam logic [1:0] CFG_LOWER_TICKS   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_TICKS = 2'd1;
  localparam logic [1:0] CFG_RETRACT_TICKS = 2'd2;
  localparam logic [1:0] CFG_USE_LIMIT     = 2'd3;

  typedef enum logic [2:0] {
    OP_LOWER   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_RETRACT = 3'd2,
    OP_STOW    = 3'd3,
    OP_ABORT   = 3'd4,
    OP_TICK    = 3'd5,
    OP_LIMIT   = 3'd6,
    OP_UNKNOWN = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PH_STOWED         = 3'd0,
    PH_LOWERING       = 3'd1,
    PH_LOWERED        = 3'd2,
    PH_RELEASING      = 3'd3,
    PH_RELEASED       = 3'd4,
    PH_RETRACTING     = 3'd5,
    PH_RETRACT_FAILED = 3'd6,
    PH_ABORTED        = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    SP_HOLD    = 2'd0,
    SP_PAYOUT  = 2'd1,
    SP_RETRACT = 2'd2
  } spool_t;

  typedef struct packed {
    logic [CFG_W-1:0] lower_ticks;
    logic [CFG_W-1:0] release_ticks;
    logic [CFG_W-1:0] retract_ticks;
    logic             limit_veto_en;
  } twseq_cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   timer_running;
    spool_t spool_now;
    logic   hook_now;
    logic   limit_seen;
    logic   limit_level;
  } twseq_state_t;

  typedef struct packed {
    logic   fallback_warning;
    logic   announce;
    logic   hook_open;
    spool_t spool_mode;
    phase_t phase_code;
  } twseq_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/twseq_step.sv
// ----------------------------------------------------------------------------
// twseq_step
// next-state and result logic for one request of the winch sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module twseq_step
  import twseq_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  op_t                   op,
  input  logic                  limit_closed,
  input  twseq_cfg_t            cfg,
  input  twseq_state_t          st,
  input  logic [TICK_WIDTH-1:0] ticks_left,
  output twseq_state_t          st_next,
  output logic [TICK_WIDTH-1:0] ticks_left_next,
  output logic                  has_result,
  output twseq_result_t         result
);

  localparam int DW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam logic [DW-1:0] TICK_MAX = DW'({TICK_WIDTH{1'b1}});

  logic [CFG_W-1:0]      dur;
  logic [DW-1:0]         dur_ext;
  logic [TICK_WIDTH-1:0] load_ticks;
  logic                  announce;
  logic                  warn;

  assign dur = (op == OP_RELEASE) ? cfg.release_ticks :
               (op == OP_RETRACT) ? cfg.retract_ticks : cfg.lower_ticks;
  assign dur_ext = DW'(dur);
  // saturate the duration into the counter range
  assign load_ticks = (dur_ext > TICK_MAX) ? TICK_WIDTH'(TICK_MAX)
                                           : TICK_WIDTH'(dur_ext);

  always_comb begin
    st_next         = st;
    ticks_left_next = ticks_left;
    has_result      = 1'b1;
    announce        = 1'b0;
    warn            = 1'b0;
    case (op)
      OP_LOWER, OP_RELEASE, OP_RETRACT: begin
        ticks_left_next     = load_ticks;
        st_next.timer_running = 1'b1;
        announce            = 1'b1;
        if (op == OP_LOWER) begin
          st_next.phase     = PH_LOWERING;
          st_next.hook_now  = 1'b0;
          st_next.spool_now = SP_PAYOUT;
        end else if (op == OP_RETRACT) begin
          st_next.phase     = PH_RETRACTING;
          st_next.hook_now  = 1'b0;
          st_next.spool_now = SP_RETRACT;
        end else begin
          st_next.phase     = PH_RELEASING;
          st_next.hook_now  = 1'b1;
          st_next.spool_now = SP_HOLD;
        end
      end
      OP_STOW, OP_ABORT: begin
        st_next.phase         = (op == OP_STOW) ? PH_STOWED : PH_ABORTED;
        st_next.spool_now     = SP_HOLD;
        st_next.hook_now      = 1'b0;
        st_next.timer_running = 1'b0;
        ticks_left_next       = '0;
        announce              = 1'b1;
      end
      OP_TICK: begin
        if (st.timer_running) begin
          if (ticks_left > TICK_WIDTH'(1)) begin
            ticks_left_next = ticks_left - TICK_WIDTH'(1);
          end else begin
            ticks_left_next       = '0;
            st_next.timer_running = 1'b0;
            st_next.spool_now     = SP_HOLD;
            case (st.phase)
              PH_LOWERING: begin
                st_next.phase = PH_LOWERED;
                announce      = 1'b1;
              end
              PH_RELEASING: begin
                st_next.phase = PH_RELEASED;
                announce      = 1'b1;
              end
              PH_RETRACTING: begin
                st_next.hook_now = 1'b0;
                announce         = 1'b1;
                // with the veto enabled, an open switch seen last vetoes the stowed report
                if (cfg.limit_veto_en && st.limit_seen && !st.limit_level) begin
                  st_next.phase = PH_RETRACT_FAILED;
                end else begin
                  warn          = cfg.limit_veto_en && !st.limit_seen;
                  st_next.phase = PH_STOWED;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_LIMIT: begin
        st_next.limit_level = limit_closed;
        st_next.limit_seen  = 1'b1;
        has_result          = 1'b0;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign result.phase_code       = st_next.phase;
  assign result.spool_mode       = st_next.spool_now;
  assign result.hook_open        = st_next.hook_now;
  assign result.announce         = announce;
  assign result.fallback_warning = warn;

endmodule

`default_nettype wire

>>> hw/rtl/timed_winch_sequencer.sv
// ----------------------------------------------------------------------------
// timed_winch_sequencer
// open-loop, tick-timed winch sequencer with limit switch check
// ----------------------------------------------------------------------------
// Takes one request per clock unless the result path stalls: a command, a
// timer tick or a limit switch sample. Each request is registered, then the
// sequencer state and result register are updated from it when it advances,
// so requests may follow back to back. Commands (lower, release, retract,
// stow, abort) and ticks each give one result; limit samples and unknown ops
// give none. s_tready drops only while the result register is full and
// m_tready is low. Registers are to be written through the cfg port only
// while the block is idle, which it does not enforce; writes are always taken.
`default_nettype none

module timed_winch_sequencer
  import twseq_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // op[2:0], limit_closed[3], zero[7:4]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // phase_code[2:0], spool_mode[4:3], hook_open[5],
                                // announce[6], fallback_warning[7]
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  `include "timed_winch_sequencer_assert.svh"

  twseq_cfg_t            cfg;
  twseq_state_t          st;
  twseq_state_t          st_next;
  logic [TICK_WIDTH-1:0] ticks_left;
  logic [TICK_WIDTH-1:0] ticks_left_next;

  logic          in_valid;
  op_t           in_op;
  logic          in_limit_closed;
  logic          has_result;
  twseq_result_t step_result;
  logic          advance;

  twseq_result_t out_result;
  logic          out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_ticks   <= LOWER_TICKS_RST;
      cfg.release_ticks <= RELEASE_TICKS_RST;
      cfg.retract_ticks <= RETRACT_TICKS_RST;
      cfg.limit_veto_en <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOWER_TICKS:   cfg.lower_ticks   <= cfg_data;
        CFG_RELEASE_TICKS: cfg.release_ticks <= cfg_data;
        CFG_RETRACT_TICKS: cfg.retract_ticks <= cfg_data;
        CFG_USE_LIMIT:     cfg.limit_veto_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register moves on unless its result has nowhere to go
  assign advance  = in_valid && (!has_result || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op           <= op_t'(s_tdata[2:0]);
      in_limit_closed <= s_tdata[3];
    end
  end

  twseq_step #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_step (
    .op              (in_op),
    .limit_closed    (in_limit_closed),
    .cfg             (cfg),
    .st              (st),
    .ticks_left      (ticks_left),
    .st_next         (st_next),
    .ticks_left_next (ticks_left_next),
    .has_result      (has_result),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_STOWED;
      st.timer_running <= 1'b0;
      st.spool_now     <= SP_HOLD;
      st.hook_now      <= 1'b0;
      st.limit_seen    <= 1'b0;
      st.limit_level   <= 1'b0;
      ticks_left       <= '0;
    end else if (advance) begin
      st         <= st_next;
      ticks_left <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.fallback_warning, out_result.announce,
                     out_result.hook_open, out_result.spool_mode,
                     out_result.phase_code};

  `TWSEQ_ASSERT_IMPLIES(a_idle_timer_clear, clk, rst, !st.timer_running, ticks_left == '0)
  `TWSEQ_ASSERT_IMPLIES(a_payout_lowering, clk, rst, st.spool_now == SP_PAYOUT,
                        st.phase == PH_LOWERING)
  `TWSEQ_ASSERT_IMPLIES(a_hook_open_phase, clk, rst, st.hook_now,
                        st.phase == PH_RELEASING || st.phase == PH_RELEASED)
  `TWSEQ_ASSERT_NEXT(a_warn_on_stow, clk, rst,
                     advance && has_result && step_result.fallback_warning,
                     m_tvalid && m_tdata[6] && m_tdata[2:0] == PH_STOWED)

endmodule

`default_nettype wire

>>> test/timed_winch_sequencer_tb.sv
// ----------------------------------------------------------------------------
// timed_winch_sequencer_tb
// self-checking bench for the tick-timed winch sequencer
// ----------------------------------------------------------------------------
// Drives commands, ticks and limit switch samples on the request stream and
// predicts every result from a behavioral copy of the sequencer. Directed
// requests cover each op, timer expiry at lengths 0, 1 and 2, the released
// hold, the limit switch veto and the never-sampled warning. Random missions
// (lower, release, retract with switch samples and noise) then run under
// changing timer lengths. The sender works in bursts and the receiver
// stalls, including one long hold-off per random register setting.
// ----------------------------------------------------------------------------
module timed_winch_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twseq_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEM_TARGET     = 1450;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PHASE_ITEMS     = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // op[2:0], limit_closed[3], zero[7:4]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // phase_code[2:0], spool_mode[4:3], hook_open[5],
                          // announce[6], fallback_warning[7]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  timed_winch_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  class winch_scoreboard;
    logic [15:0]   lower_len;
    logic [15:0]   release_len;
    logic [15:0]   retract_len;
    bit            veto_on;
    phase_t        phase_now;
    bit            timer_on;
    logic [15:0]   ticks_left;
    spool_t        spool_cmd;
    bit            hook_cmd;
    bit            switch_seen;
    bit            switch_level;
    twseq_result_t expected_q[$];
    int            mismatches;
    int            results_seen;
    int            timer_ends[8];
    int            warnings;

    function new();
      lower_len    = LOWER_TICKS_RST;
      release_len  = RELEASE_TICKS_RST;
      retract_len  = RETRACT_TICKS_RST;
      veto_on      = 1'b0;
      phase_now    = PH_STOWED;
      timer_on     = 1'b0;
      ticks_left   = '0;
      spool_cmd    = SP_HOLD;
      hook_cmd     = 1'b0;
      switch_seen  = 1'b0;
      switch_level = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      warnings     = 0;
      foreach (timer_ends[i]) timer_ends[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_LOWER_TICKS:   lower_len   = val;
        CFG_RELEASE_TICKS: release_len = val;
        CFG_RETRACT_TICKS: retract_len = val;
        CFG_USE_LIMIT:     veto_on     = val[0];
        default: ;
      endcase
    endfunction

    // pay out and reel in keep the hook closed, release holds and opens it
    function void start_timer(phase_t ph, logic [15:0] len);
      phase_now  = ph;
      ticks_left = len;
      timer_on   = 1'b1;
      case (ph)
        PH_LOWERING:   begin spool_cmd = SP_PAYOUT;  hook_cmd = 1'b0; end
        PH_RETRACTING: begin spool_cmd = SP_RETRACT; hook_cmd = 1'b0; end
        default:       begin spool_cmd = SP_HOLD;    hook_cmd = 1'b1; end
      endcase
    endfunction

    function void halt(phase_t ph);
      phase_now  = ph;
      timer_on   = 1'b0;
      ticks_left = '0;
      spool_cmd  = SP_HOLD;
      hook_cmd   = 1'b0;
    endfunction

    function void note_request(logic [7:0] data);
      op_t           op;
      twseq_result_t r;
      op                 = op_t'(data[2:0]);
      r.announce         = 1'b0;
      r.fallback_warning = 1'b0;
      case (op)
        OP_LOWER:   begin start_timer(PH_LOWERING, lower_len);     r.announce = 1'b1; end
        OP_RELEASE: begin start_timer(PH_RELEASING, release_len);  r.announce = 1'b1; end
        OP_RETRACT: begin start_timer(PH_RETRACTING, retract_len); r.announce = 1'b1; end
        OP_STOW:    begin halt(PH_STOWED);  r.announce = 1'b1; end
        OP_ABORT:   begin halt(PH_ABORTED); r.announce = 1'b1; end
        OP_TICK: begin
          if (timer_on) begin
            if (ticks_left > 16'd1) begin
              ticks_left = ticks_left - 16'd1;
            end else begin
              ticks_left = '0;
              timer_on   = 1'b0;
              spool_cmd  = SP_HOLD;
              case (phase_now)
                PH_LOWERING: begin
                  phase_now  = PH_LOWERED;
                  r.announce = 1'b1;
                end
                PH_RELEASING: begin
                  // hook stays open after the release time
                  phase_now  = PH_RELEASED;
                  r.announce = 1'b1;
                end
                PH_RETRACTING: begin
                  hook_cmd   = 1'b0;
                  r.announce = 1'b1;
                  if (veto_on && switch_seen && !switch_level) begin
                    phase_now = PH_RETRACT_FAILED;
                  end else begin
                    r.fallback_warning = veto_on && !switch_seen;
                    phase_now          = PH_STOWED;
                  end
                end
                default: ;
              endcase
              if (r.announce) timer_ends[int'(phase_now)]++;
              if (r.fallback_warning) warnings++;
            end
          end
        end
        OP_LIMIT: begin
          switch_level = data[3];
          switch_seen  = 1'b1;
          return;
        end
        default: return;
      endcase
      r.phase_code = phase_now;
      r.spool_mode = spool_cmd;
      r.hook_open  = hook_cmd;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: result %0d %s expected %0d, got %0d",
                 $time, results_seen, name, want, got);
      end
    endfunction

    function void check_result(logic [7:0] data);
      twseq_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result 0x%02h arrived with no request waiting, expected none",
                 $time, data);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      compare_field("phase_code", want.phase_code, data[2:0]);
      compare_field("spool_mode", want.spool_mode, data[4:3]);
      compare_field("hook_open", want.hook_open, data[5]);
      compare_field("announce", want.announce, data[6]);
      compare_field("fallback_warning", want.fallback_warning, data[7]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  winch_scoreboard sb;
  int burst_left;
  bit tx_gaps;
  int items_sent;
  bit hold_off_req;
  int hold_offs_done;
  int stall_cycles = 0;

  // request and result monitors
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stall_cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on demand
  initial begin
    int mode;
    int mode_left;
    int cnt;
    m_tready  = 1'b0;
    mode      = 0;
    mode_left = 0;
    cnt       = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        cnt++;
        case (mode)
          0:       m_tready = 1'b1;
          1:       m_tready = 1'($urandom_range(0, 1));
          2:       m_tready = ($urandom_range(0, 4) == 0);
          default: m_tready = (cnt % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_req(op_t op, logic lc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gaps) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {4'b0000, lc, op};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (op != OP_UNKNOWN) items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    // a limit sample or an unknown op may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly short timers so missions reach their end, now and then the extremes
  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0)
      send_req(op_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_ticks(logic [15:0] len);
    int n;
    if (len <= 16'd8) n = (len == 16'd0) ? 1 : int'(len);
    else n = $urandom_range(1, 8);
    if (len <= 16'd8) n += $urandom_range(0, 2);
    // now and then send one tick fewer, which can stop short of the end
    if (n > 1 && $urandom_range(0, 9) == 0) n--;
    repeat (n) begin
      maybe_noise();
      send_req(OP_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_mission();
    int plan;
    plan = $urandom_range(0, 3);
    send_req(OP_LOWER, 1'($urandom_range(0, 1)));
    send_ticks(sb.lower_len);
    if ($urandom_range(0, 7) == 0) begin
      send_req(OP_ABORT, 1'($urandom_range(0, 1)));
      return;
    end
    maybe_noise();
    send_req(OP_RELEASE, 1'($urandom_range(0, 1)));
    send_ticks(sb.release_len);
    // switch samples around the reel-in decide stowed or retract failed
    if (plan == 1) send_req(OP_LIMIT, 1'b1);
    if (plan == 2) send_req(OP_LIMIT, 1'b0);
    send_req(OP_RETRACT, 1'($urandom_range(0, 1)));
    if (plan == 3) send_req(OP_LIMIT, 1'($urandom_range(0, 1)));
    send_ticks(sb.retract_len);
    if ($urandom_range(0, 3) == 0) send_req(OP_STOW, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase_start;
    int settings;
    sb             = new();
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_LOWER_TICKS;
    cfg_data       = '0;
    burst_left     = 0;
    tx_gaps        = 1'b1;
    items_sent     = 0;
    hold_off_req   = 1'b0;
    hold_offs_done = 0;
    settings       = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset lengths: commands interrupt running timers, idle ticks
    send_req(OP_TICK, 1'b0);
    send_req(OP_UNKNOWN, 1'b1);
    send_req(OP_LOWER, 1'b0);
    send_req(OP_TICK, 1'b1);
    send_req(OP_RELEASE, 1'b0);
    send_req(OP_RETRACT, 1'b1);
    send_req(OP_STOW, 1'b0);
    send_req(OP_ABORT, 1'b1);
    send_req(OP_TICK, 1'b0);
    drain();

    // zero, one and two tick timers with the switch veto on
    write_reg(CFG_LOWER_TICKS, 16'h0000);
    write_reg(CFG_RELEASE_TICKS, 16'h0001);
    write_reg(CFG_RETRACT_TICKS, 16'h0002);
    write_reg(CFG_USE_LIMIT, 16'hffff);
    send_req(OP_LOWER, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_RELEASE, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_TICK, 1'b0);
    // switch enabled but never sampled yet
    send_req(OP_RETRACT, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_LIMIT, 1'b0);
    send_req(OP_RETRACT, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_TICK, 1'b0);
    send_req(OP_LIMIT, 1'b1);
    send_req(OP_RETRACT, 1'b1);
    send_req(OP_TICK, 1'b1);
    send_req(OP_TICK, 1'b1);
    send_req(OP_ABORT, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      drain();
      write_reg(CFG_LOWER_TICKS, pick_len());
      write_reg(CFG_RELEASE_TICKS, pick_len());
      write_reg(CFG_RETRACT_TICKS, pick_len());
      write_reg(CFG_USE_LIMIT, 16'($urandom_range(0, 65535)));
      settings++;
      tx_gaps     = ($urandom_range(0, 2) != 0);
      phase_start = items_sent;
      // long receiver hold-off while requests keep coming
      @(posedge clk);
      hold_off_req = 1'b1;
      burst_left   = 40;
      repeat (20) send_req(OP_TICK, 1'($urandom_range(0, 1)));
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
        run_mission();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d requests under %0d register settings, %0d results checked, %0d hold-offs",
             items_sent, settings, sb.results_seen, hold_offs_done);
    $display("timer ends: lowered %0d, released %0d, stowed %0d, retract failed %0d, warnings %0d",
             sb.timer_ends[int'(PH_LOWERED)], sb.timer_ends[int'(PH_RELEASED)],
             sb.timer_ends[int'(PH_STOWED)], sb.timer_ends[int'(PH_RETRACT_FAILED)],
             sb.warnings);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/twseq_pkg.sv
hw/rtl/twseq_step.sv
hw/rtl/timed_winch_sequencer.sv
test/timed_winch_sequencer_tb.sv
